### sv/ptt_pkg.sv
package ptt_pkg;

	localparam int SLOTS = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MAX_FIRED = 16;
	localparam int FIRED_W = $clog2(MAX_FIRED + 1);

	localparam logic [2:0] FUNC_ADD = 3'd0;
	localparam logic [2:0] FUNC_STOP = 3'd1;
	localparam logic [2:0] FUNC_CLEAR = 3'd2;
	localparam logic [2:0] FUNC_RESTART_ALL = 3'd3;
	localparam logic [2:0] FUNC_TICK = 3'd4;

	typedef enum logic [2:0] {
		KIND_ADDED = 3'd0,
		KIND_FULL = 3'd1,
		KIND_BAD_INTERVAL = 3'd2,
		KIND_ACK = 3'd3,
		KIND_FIRED = 3'd4,
		KIND_TICK_DONE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_ONE,
		ST_ALL,
		ST_TICK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic add;
		logic free;
		logic set_deadline;
		logic [23:0] period;
		logic [31:0] tag;
		logic [15:0] seq;
		logic [31:0] deadline;
	} slot_wr_t;

endpackage

### sv/ptt_slots.sv
module ptt_slots (
	input logic clk,
	input logic arst_n,
	input logic [ptt_pkg::SLOT_W-1:0] idx,
	input ptt_pkg::slot_wr_t wr,
	output logic rd_valid,
	output logic [23:0] rd_period,
	output logic [31:0] rd_deadline,
	output logic [31:0] rd_tag,
	output logic [15:0] rd_seq
);

	logic [ptt_pkg::SLOTS-1:0] valid_q;
	logic [23:0] period_q [ptt_pkg::SLOTS];
	logic [31:0] deadline_q [ptt_pkg::SLOTS];
	logic [31:0] tag_q [ptt_pkg::SLOTS];
	logic [15:0] seq_q [ptt_pkg::SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.add) begin
			valid_q[idx] <= 1'b1;
		end else if (wr.free) begin
			valid_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.add) begin
			period_q[idx] <= wr.period;
			tag_q[idx] <= wr.tag;
			seq_q[idx] <= wr.seq;
		end
		if (wr.set_deadline) begin
			deadline_q[idx] <= wr.deadline;
		end
	end

	assign rd_valid = valid_q[idx];
	assign rd_period = period_q[idx];
	assign rd_deadline = deadline_q[idx];
	assign rd_tag = tag_q[idx];
	assign rd_seq = seq_q[idx];

endmodule

### sv/periodic_timer_table_top.sv
// Table of periodic timers driven by commands.
// A command word is taken at a rising edge with start high and busy low; it
// carries func, now, interval, tag and timer_id. Busy stays high while the
// command is worked on and no further command is taken.
// Every result word is shown for exactly one cycle with strobe high; the
// receiver cannot stall, so results are simply presented and gone.
// Add scans the slots one per cycle for the first free one and answers with
// added, full or bad interval. Stop and clear answer with an ack, as do the
// unused function codes. Restart all scans every slot. Tick scans every slot,
// one per cycle, reporting each expired timer as a fired word the cycle after
// its slot is visited, then closes with tick done. The scan goes through the
// slot store one entry per cycle, through a single adder and comparator. The
// final word of a command carries last and appears in the cycle in which busy
// has already dropped.
// Reset empties the table, clears the sequence counter and returns to idle.
module periodic_timer_table_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] func,
	input logic [31:0] now,
	input logic [23:0] interval,
	input logic [31:0] tag,
	input logic [23:0] timer_id,
	output logic strobe,
	output logic [2:0] kind,
	output logic [23:0] result_id,
	output logic [31:0] fired_tag,
	output logic last
);

	localparam int SW = ptt_pkg::SLOT_W;
	localparam int FW = ptt_pkg::FIRED_W;

	ptt_pkg::state_t state_q, state_d;
	logic [SW-1:0] idx_q;
	logic [FW-1:0] fired_q;
	logic [15:0] seq_q;
	logic strobe_q;
	logic [2:0] func_q;
	logic [31:0] now_q;
	logic [23:0] interval_q;
	logic [31:0] tag_q;
	logic [23:0] timer_id_q;
	logic slot_ok_q;
	logic [2:0] kind_q;
	logic [23:0] result_id_q;
	logic [31:0] fired_tag_q;
	logic last_q;

	logic accept;
	logic rd_valid;
	logic [23:0] rd_period;
	logic [31:0] rd_deadline;
	logic [31:0] rd_tag;
	logic [15:0] rd_seq;
	ptt_pkg::slot_wr_t wr;
	logic [23:0] period_src;
	logic [31:0] sum;
	logic expired;
	logic last_slot;
	logic match;
	logic idx_inc;
	logic fired_inc;
	logic seq_inc;
	logic emit;
	ptt_pkg::kind_t emit_kind;
	logic [23:0] emit_id;
	logic [31:0] emit_tag;
	logic emit_last;

	ptt_slots u_slots (
		.clk(clk),
		.arst_n(arst_n),
		.idx(idx_q),
		.wr(wr),
		.rd_valid(rd_valid),
		.rd_period(rd_period),
		.rd_deadline(rd_deadline),
		.rd_tag(rd_tag),
		.rd_seq(rd_seq)
	);

	assign busy = (state_q != ptt_pkg::ST_IDLE);
	assign accept = start && !busy;

	// One adder serves add, clear, restart all and tick; the expiry comparator serves tick.
	assign period_src = (state_q == ptt_pkg::ST_ADD) ? interval_q : rd_period;
	assign sum = now_q + 32'(period_src);
	assign expired = rd_valid && (now_q > rd_deadline);
	assign last_slot = (idx_q == SW'(ptt_pkg::SLOTS - 1));
	assign match = slot_ok_q && rd_valid && (rd_seq == timer_id_q[15:0]);

	always_comb begin
		state_d = state_q;
		wr = '0;
		wr.period = interval_q;
		wr.tag = tag_q;
		wr.seq = seq_q;
		wr.deadline = sum;
		idx_inc = 1'b0;
		fired_inc = 1'b0;
		seq_inc = 1'b0;
		emit = 1'b0;
		emit_kind = ptt_pkg::KIND_ACK;
		emit_id = '0;
		emit_tag = '0;
		emit_last = 1'b1;
		unique case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (func)
						ptt_pkg::FUNC_ADD: state_d = ptt_pkg::ST_ADD;
						ptt_pkg::FUNC_RESTART_ALL: state_d = ptt_pkg::ST_ALL;
						ptt_pkg::FUNC_TICK: state_d = ptt_pkg::ST_TICK;
						default: state_d = ptt_pkg::ST_ONE;
					endcase
				end
			end
			ptt_pkg::ST_ADD: begin
				if (interval_q == '0) begin
					emit = 1'b1;
					emit_kind = ptt_pkg::KIND_BAD_INTERVAL;
					state_d = ptt_pkg::ST_IDLE;
				end else if (!rd_valid) begin
					wr.add = 1'b1;
					wr.set_deadline = 1'b1;
					seq_inc = 1'b1;
					emit = 1'b1;
					emit_kind = ptt_pkg::KIND_ADDED;
					emit_id = {8'(idx_q), seq_q};
					state_d = ptt_pkg::ST_IDLE;
				end else if (last_slot) begin
					emit = 1'b1;
					emit_kind = ptt_pkg::KIND_FULL;
					state_d = ptt_pkg::ST_IDLE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			ptt_pkg::ST_ONE: begin
				wr.free = (func_q == ptt_pkg::FUNC_STOP) && match;
				wr.set_deadline = (func_q == ptt_pkg::FUNC_CLEAR) && match;
				emit = 1'b1;
				state_d = ptt_pkg::ST_IDLE;
			end
			ptt_pkg::ST_ALL: begin
				wr.set_deadline = rd_valid;
				if (last_slot) begin
					emit = 1'b1;
					state_d = ptt_pkg::ST_IDLE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			ptt_pkg::ST_TICK: begin
				if (expired && (fired_q < FW'(ptt_pkg::MAX_FIRED))) begin
					wr.set_deadline = 1'b1;
					fired_inc = 1'b1;
					emit = 1'b1;
					emit_kind = ptt_pkg::KIND_FIRED;
					emit_id = {8'(idx_q), rd_seq};
					emit_tag = rd_tag;
					emit_last = 1'b0;
				end
				if (last_slot) begin
					state_d = ptt_pkg::ST_DONE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			ptt_pkg::ST_DONE: begin
				emit = 1'b1;
				emit_kind = ptt_pkg::KIND_TICK_DONE;
				state_d = ptt_pkg::ST_IDLE;
			end
			default: begin
				state_d = ptt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			fired_q <= '0;
			seq_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (seq_inc) begin
				seq_q <= seq_q + 16'd1;
			end
			if (accept) begin
				fired_q <= '0;
				if ((func == ptt_pkg::FUNC_STOP) || (func == ptt_pkg::FUNC_CLEAR)) begin
					idx_q <= timer_id[16 +: SW];
				end else begin
					idx_q <= '0;
				end
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + SW'(1);
				end
				if (fired_inc) begin
					fired_q <= fired_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			now_q <= now;
			interval_q <= interval;
			tag_q <= tag;
			timer_id_q <= timer_id;
			slot_ok_q <= ({1'b0, timer_id[23:16]} < 9'(ptt_pkg::SLOTS));
		end
		if (emit) begin
			kind_q <= emit_kind;
			result_id_q <= emit_id;
			fired_tag_q <= emit_tag;
			last_q <= emit_last;
		end
	end

	assign strobe = strobe_q;
	assign kind = kind_q;
	assign result_id = result_id_q;
	assign fired_tag = fired_tag_q;
	assign last = last_q;

endmodule

### sv/ptt_checker.sv
module ptt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic [2:0] kind,
	input logic last
);

	// Every accepted command keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not make the block busy");

	// The closing word of a command appears exactly as busy drops.
	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy dropped without a closing word");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("closing word shown while still busy");

	// Only fired words can precede the closing word of a tick.
	a_not_last_fired: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && (kind == ptt_pkg::KIND_FIRED))
		else $error("intermediate word is not a fired timer");

	a_strobe_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("word shown without a command in progress");

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.strobe(strobe),
	.kind(kind),
	.last(last)
);

### bench/tb_top.sv
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX = 10;
	localparam int RANDOM_ITEMS = 410;

	typedef struct packed {
		ptt_pkg::kind_t kind;
		logic [23:0] id;
		logic [31:0] tag;
		logic last;
	} timer_word_t;

	class timer_table_tracker;
		bit live [ptt_pkg::SLOTS];
		logic [23:0] period [ptt_pkg::SLOTS];
		logic [31:0] deadline [ptt_pkg::SLOTS];
		logic [31:0] tag_of [ptt_pkg::SLOTS];
		logic [15:0] seq [ptt_pkg::SLOTS];
		logic [15:0] next_seq;
		timer_word_t pending [$];
		int errors;
		int words_checked;
		int fired_count;
		int full_count;
		int commands;

		function new();
			for (int s = 0; s < ptt_pkg::SLOTS; s++) begin
				live[s] = 1'b0;
				period[s] = '0;
				deadline[s] = '0;
				tag_of[s] = '0;
				seq[s] = '0;
			end
			next_seq = '0;
			errors = 0;
			words_checked = 0;
			fired_count = 0;
			full_count = 0;
			commands = 0;
		endfunction

		function logic [23:0] id_of(int s);
			logic [7:0] slot_byte;
			slot_byte = s[7:0];
			return {slot_byte, seq[s]};
		endfunction

		function int find_slot(logic [23:0] id);
			int s;
			s = int'(id[23:16]);
			if (s >= ptt_pkg::SLOTS)
				return -1;
			if (!live[s])
				return -1;
			if (seq[s] != id[15:0])
				return -1;
			return s;
		endfunction

		function void push_word(ptt_pkg::kind_t k, logic [23:0] id, logic [31:0] tg,
				logic lst);
			timer_word_t w;
			w.kind = k;
			w.id = id;
			w.tag = tg;
			w.last = lst;
			pending.push_back(w);
		endfunction

		function void note_command(logic [2:0] f, logic [31:0] t_now, logic [23:0] ivl,
				logic [31:0] tg, logic [23:0] id);
			int s;
			int n;
			bit placed;
			commands++;
			case (f)
				ptt_pkg::FUNC_ADD: begin
					if (ivl == '0) begin
						push_word(ptt_pkg::KIND_BAD_INTERVAL, '0, '0, 1'b1);
					end else begin
						placed = 1'b0;
						for (s = 0; s < ptt_pkg::SLOTS && !placed; s++) begin
							if (!live[s]) begin
								live[s] = 1'b1;
								period[s] = ivl;
								tag_of[s] = tg;
								deadline[s] = t_now + {8'd0, ivl};
								seq[s] = next_seq;
								next_seq = next_seq + 16'd1;
								push_word(ptt_pkg::KIND_ADDED, id_of(s), '0, 1'b1);
								placed = 1'b1;
							end
						end
						if (!placed) begin
							full_count++;
							push_word(ptt_pkg::KIND_FULL, '0, '0, 1'b1);
						end
					end
				end
				ptt_pkg::FUNC_STOP: begin
					s = find_slot(id);
					if (s >= 0)
						live[s] = 1'b0;
					push_word(ptt_pkg::KIND_ACK, '0, '0, 1'b1);
				end
				ptt_pkg::FUNC_CLEAR: begin
					s = find_slot(id);
					if (s >= 0)
						deadline[s] = t_now + {8'd0, period[s]};
					push_word(ptt_pkg::KIND_ACK, '0, '0, 1'b1);
				end
				ptt_pkg::FUNC_RESTART_ALL: begin
					for (s = 0; s < ptt_pkg::SLOTS; s++)
						if (live[s])
							deadline[s] = t_now + {8'd0, period[s]};
					push_word(ptt_pkg::KIND_ACK, '0, '0, 1'b1);
				end
				ptt_pkg::FUNC_TICK: begin
					n = 0;
					for (s = 0; s < ptt_pkg::SLOTS && n < ptt_pkg::MAX_FIRED; s++) begin
						if (live[s] && t_now > deadline[s]) begin
							deadline[s] = {8'd0, period[s]} + t_now;
							push_word(ptt_pkg::KIND_FIRED, id_of(s), tag_of[s], 1'b0);
							fired_count++;
							n++;
						end
					end
					push_word(ptt_pkg::KIND_TICK_DONE, '0, '0, 1'b1);
				end
				default: begin
					push_word(ptt_pkg::KIND_ACK, '0, '0, 1'b1);
				end
			endcase
		endfunction

		function void check_word(timer_word_t got);
			timer_word_t want;
			words_checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("Unexpected result word: kind=%0d id=%h tag=%h last=%b",
						got.kind, got.id, got.tag, got.last);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display({"Mismatch: expected kind=%0d id=%h tag=%h last=%b, ",
						"got kind=%0d id=%h tag=%h last=%b"},
						want.kind, want.id, want.tag, want.last,
						got.kind, got.id, got.tag, got.last);
			end
		endfunction

		function logic [23:0] pick_id();
			int r;
			int s;
			int tries;
			r = $urandom_range(0, 99);
			if (r < 10)
				return {8'($urandom_range(ptt_pkg::SLOTS, 255)), 16'($urandom)};
			for (tries = 0; tries < 32; tries++) begin
				s = $urandom_range(0, ptt_pkg::SLOTS - 1);
				if (live[s]) begin
					if (r < 20)
						return {s[7:0], seq[s] + 16'd1};
					return id_of(s);
				end
			end
			return 24'($urandom);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] func = '0;
	logic [31:0] now = '0;
	logic [23:0] interval = '0;
	logic [31:0] tag = '0;
	logic [23:0] timer_id = '0;
	logic busy;
	logic strobe;
	logic [2:0] kind;
	logic [23:0] result_id;
	logic [31:0] fired_tag;
	logic last;

	timer_table_tracker sb = new();
	int cycles = 0;
	logic [31:0] wall_s = '0;
	bit no_idle = 1'b0;

	periodic_timer_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.now(now),
		.interval(interval),
		.tag(tag),
		.timer_id(timer_id),
		.strobe(strobe),
		.kind(kind),
		.result_id(result_id),
		.fired_tag(fired_tag),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		timer_word_t got;
		if (arst_n && strobe) begin
			got.kind = ptt_pkg::kind_t'(kind);
			got.id = result_id;
			got.tag = fired_tag;
			got.last = last;
			sb.check_word(got);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words outstanding", cycles,
				sb.pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [23:0] pick_interval();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 24'($urandom_range(1, 6));
		if (r < 90)
			return 24'($urandom_range(7, 200));
		if (r < 97)
			return 24'($urandom);
		return 24'hFFFFFF;
	endfunction

	// Holds start high with the new word until an edge finds busy low.
	task automatic issue(input logic [2:0] f, input logic [31:0] t, input logic [23:0] ivl,
			input logic [31:0] tg, input logic [23:0] id, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		now <= t;
		interval <= ivl;
		tag <= tg;
		timer_id <= id;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(f, t, ivl, tg, id);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending.size() != 0 || busy);
	endtask

	initial begin
		int r;
		logic [2:0] f;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ptt_pkg::FUNC_ADD, 32'd0, 24'd0, 32'hFFFFFFFF, 24'hFFFFFF, 0);
		issue(ptt_pkg::FUNC_ADD, 32'hFFFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 24'd0, 0);
		issue(ptt_pkg::FUNC_TICK, 32'd0, 24'hFFFFFF, 32'd0, 24'hFFFFFF, 0);
		issue(ptt_pkg::FUNC_STOP, 32'd0, 24'd0, 32'd0, 24'hFFFFFF, 1);
		issue(ptt_pkg::FUNC_STOP, 32'd0, 24'd0, 32'd0, 24'h000001, 0);
		issue(ptt_pkg::FUNC_STOP, 32'd0, 24'd0, 32'd0, 24'h050000, 0);
		issue(ptt_pkg::FUNC_CLEAR, 32'h01000000, 24'd0, 32'd0, 24'h000000, 2);
		issue(ptt_pkg::FUNC_RESTART_ALL, 32'h00000010, 24'd0, 32'd0, 24'd0, 0);
		for (int i = 1; i < ptt_pkg::SLOTS; i++)
			issue(ptt_pkg::FUNC_ADD, 32'h00000020, 24'd1, $urandom, 24'd0, i % 3);
		issue(ptt_pkg::FUNC_ADD, 32'h00000020, 24'd3, 32'h12345678, 24'd0, 0);
		issue(ptt_pkg::FUNC_TICK, 32'hFFFFFFFF, 24'd0, 32'd0, 24'd0, 0);
		issue(FUNC_SPARE_LO, $urandom, 24'($urandom), $urandom, 24'($urandom), 0);
		issue(FUNC_SPARE_MID, $urandom, 24'($urandom), $urandom, 24'($urandom), 0);
		issue(FUNC_SPARE_HI, $urandom, 24'($urandom), $urandom, 24'($urandom), 0);
		drain();
		wall_s = 32'h00000100;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 99)
				drain();
			if (i % 60 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < 2)
				wall_s = $urandom;
			else if (r < 4)
				wall_s = 32'hFFFFFF00 + 32'($urandom_range(0, 200));
			else
				wall_s = wall_s + 32'($urandom_range(0, 2));
			r = $urandom_range(0, 99);
			if (r < 30)
				issue(ptt_pkg::FUNC_ADD, wall_s, pick_interval(), $urandom, 24'($urandom),
					pick_gap());
			else if (r < 58)
				issue(ptt_pkg::FUNC_TICK, wall_s, 24'($urandom), $urandom, 24'($urandom),
					pick_gap());
			else if (r < 72)
				issue(ptt_pkg::FUNC_STOP, wall_s, 24'($urandom), $urandom, sb.pick_id(),
					pick_gap());
			else if (r < 84)
				issue(ptt_pkg::FUNC_CLEAR, wall_s, 24'($urandom), $urandom, sb.pick_id(),
					pick_gap());
			else if (r < 89)
				issue(ptt_pkg::FUNC_RESTART_ALL, wall_s, 24'($urandom), $urandom,
					24'($urandom), pick_gap());
			else if (r < 94)
				issue(ptt_pkg::FUNC_ADD, wall_s, 24'd0, $urandom, 24'($urandom), pick_gap());
			else if (r < 97) begin
				f = ($urandom_range(0, 1) == 0) ? ptt_pkg::FUNC_STOP : ptt_pkg::FUNC_CLEAR;
				issue(f, $urandom, 24'($urandom), $urandom, 24'($urandom), pick_gap());
			end else begin
				f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
				issue(f, $urandom, 24'($urandom), $urandom, 24'($urandom), pick_gap());
			end
		end

		drain();
		repeat (ptt_pkg::SLOTS + 8) @(posedge clk);

		$display("Covered %0d commands and %0d result words, with %0d timer firings",
			sb.commands, sb.words_checked, sb.fired_count);
		$display("and %0d adds rejected on a full table; %0d errors seen.", sb.full_count,
			sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
